/* rtl/bba_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

    localparam int MAX_BLOCKS    = 8192;
    localparam int WORD_BITS     = 32;
    localparam int MAP_WORDS     = MAX_BLOCKS / WORD_BITS;
    localparam int IDX_W         = $clog2(MAX_BLOCKS);
    localparam int CNT_W         = IDX_W + 1;
    localparam int BIT_W         = $clog2(WORD_BITS);
    localparam int WADDR_W       = $clog2(MAP_WORDS);
    localparam int WCNT_W        = WADDR_W + 1;
    localparam int S_TDATA_W     = 16;
    localparam int M_TDATA_W     = 32;

    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [BIT_W-1:0]     bitsel_t;
    typedef logic [WADDR_W-1:0]   waddr_t;
    typedef logic [WCNT_W-1:0]    wcnt_t;
    typedef logic [WORD_BITS-1:0] word_t;

    typedef enum logic [1:0] {
        FUNC_FORMAT = 2'd0,
        FUNC_ALLOC  = 2'd1,
        FUNC_FREE   = 2'd2,
        FUNC_TEST   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NO_FREE = 2'd1,
        STAT_RANGE   = 2'd2
    } status_t;

    localparam logic REG_TOTAL    = 1'b0;
    localparam logic REG_RESERVED = 1'b1;

    typedef struct packed {
        logic cap;
        logic fmt_init;
        logic fmt_step;
        logic scan_init;
        logic scan_step;
        logic rd_idx;
        logic upd;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        func_t func;
        logic  count_zero;
        logic  idx_oob;
        logic  fmt_done;
        logic  scan_found;
        logic  scan_miss;
    } stat_t;

endpackage

`default_nettype wire

/* rtl/bba_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/bba_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module bba_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    input  wire bba_pkg::stat_t stat,
    output bba_pkg::cmd_t       cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DISP   = 6'b000010,
        ST_FMT_WR = 6'b000100,
        ST_SCAN   = 6'b001000,
        ST_UPD    = 6'b010000,
        ST_FIN    = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.cap    = 1'b1;
                    state_next = ST_DISP;
                end
            end
            ST_DISP: begin
                case (stat.func)
                    bba_pkg::FUNC_FORMAT: begin
                        cmd.fmt_init = 1'b1;
                        state_next   = ST_FMT_WR;
                    end
                    bba_pkg::FUNC_ALLOC: begin
                        if (stat.count_zero) begin
                            state_next = ST_UPD;
                        end else begin
                            cmd.scan_init = 1'b1;
                            state_next    = ST_SCAN;
                        end
                    end
                    default: begin
                        cmd.rd_idx = !stat.idx_oob;
                        state_next = ST_UPD;
                    end
                endcase
            end
            ST_FMT_WR: begin
                if (stat.fmt_done) begin
                    state_next = ST_UPD;
                end else begin
                    cmd.fmt_step = 1'b1;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_found || stat.scan_miss) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                cmd.upd    = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                // The result moves to the output register once it is free.
                if (!m_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/bba_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module bba_dp (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire bba_pkg::func_t                  in_func,
    input  wire bba_pkg::idx_t                   in_idx,
    input  wire bba_pkg::cnt_t                   tot_eff,
    input  wire bba_pkg::cnt_t                   res_eff,
    input  wire bba_pkg::cmd_t                   cmd,
    output bba_pkg::stat_t                       stat,
    output logic [bba_pkg::M_TDATA_W-1:0]        m_tdata
);

    // Mask of the low rem bits of a map word, all ones once rem reaches a word.
    function automatic bba_pkg::word_t low_mask(input bba_pkg::cnt_t rem);
        bba_pkg::word_t m;
        if (rem >= bba_pkg::cnt_t'(bba_pkg::WORD_BITS)) begin
            m = '1;
        end else begin
            m = (bba_pkg::word_t'(1) << rem[bba_pkg::BIT_W-1:0]) - bba_pkg::word_t'(1);
        end
        return m;
    endfunction

    bba_pkg::func_t  func_reg;
    bba_pkg::idx_t   idx_reg;
    bba_pkg::wcnt_t  ctr_reg;
    logic            chk_v_reg;
    bba_pkg::waddr_t chk_w_reg;
    logic            hit_reg;
    bba_pkg::waddr_t hit_w_reg;
    bba_pkg::bitsel_t hit_b_reg;
    bba_pkg::word_t  hit_data_reg;
    bba_pkg::cnt_t   count_reg, count_next;
    logic [bba_pkg::MAP_WORDS-1:0] valid_reg;
    logic            vq_reg;

    bba_pkg::status_t res_status_reg, res_status_next;
    bba_pkg::idx_t    res_num_reg, res_num_next;
    logic             res_bit_reg, res_bit_next;

    bba_pkg::status_t out_status_reg;
    bba_pkg::idx_t    out_num_reg;
    logic             out_bit_reg;
    bba_pkg::cnt_t    out_cnt_reg;

    logic            ram_we, ram_re;
    bba_pkg::waddr_t ram_waddr, ram_raddr;
    bba_pkg::word_t  ram_wdata, ram_q;

    logic [bba_pkg::CNT_W:0] tot_sum, res_sum;
    bba_pkg::wcnt_t  words_total, words_res;
    bba_pkg::cnt_t   fmt_base, chk_base;
    bba_pkg::word_t  dq, free_vec;
    bba_pkg::bitsel_t first_free;
    logic            idx_oob, cur_bit, scan_issue, scan_found;

    bba_ram #(
        .WIDTH(bba_pkg::WORD_BITS),
        .DEPTH(bba_pkg::MAP_WORDS)
    ) u_map (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_q)
    );

    // Word counts round the managed and reserved block counts up to whole words.
    assign tot_sum     = {1'b0, tot_eff} + (bba_pkg::CNT_W+1)'(bba_pkg::WORD_BITS - 1);
    assign res_sum     = {1'b0, res_eff} + (bba_pkg::CNT_W+1)'(bba_pkg::WORD_BITS - 1);
    assign words_total = tot_sum[bba_pkg::BIT_W +: bba_pkg::WCNT_W];
    assign words_res   = res_sum[bba_pkg::BIT_W +: bba_pkg::WCNT_W];

    assign fmt_base = bba_pkg::cnt_t'({ctr_reg[bba_pkg::WADDR_W-1:0], {bba_pkg::BIT_W{1'b0}}});
    assign chk_base = bba_pkg::cnt_t'({chk_w_reg, {bba_pkg::BIT_W{1'b0}}});

    // A word never written since the last format reads as all free.
    assign dq       = vq_reg ? ram_q : '0;
    assign free_vec = ~dq & low_mask(tot_eff - chk_base);
    assign cur_bit  = dq[idx_reg[bba_pkg::BIT_W-1:0]];
    assign idx_oob  = {1'b0, idx_reg} >= tot_eff;

    assign scan_issue = cmd.scan_step && (ctr_reg < words_total);
    assign scan_found = chk_v_reg && (free_vec != '0);

    always_comb begin
        first_free = '0;
        for (int i = bba_pkg::WORD_BITS - 1; i >= 0; i--) begin
            if (free_vec[i]) begin
                first_free = bba_pkg::bitsel_t'(i);
            end
        end
    end

    assign stat.func       = func_reg;
    assign stat.count_zero = (count_reg == '0);
    assign stat.idx_oob    = idx_oob;
    assign stat.fmt_done   = (ctr_reg >= words_res);
    assign stat.scan_found = scan_found;
    assign stat.scan_miss  = !chk_v_reg && (ctr_reg >= words_total);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        if (cmd.fmt_step && (ctr_reg < words_res)) begin
            ram_we    = 1'b1;
            ram_waddr = ctr_reg[bba_pkg::WADDR_W-1:0];
            ram_wdata = low_mask(res_eff - fmt_base);
        end
        if (scan_issue) begin
            ram_re    = 1'b1;
            ram_raddr = ctr_reg[bba_pkg::WADDR_W-1:0];
        end
        if (cmd.rd_idx) begin
            ram_re    = 1'b1;
            ram_raddr = idx_reg[bba_pkg::IDX_W-1:bba_pkg::BIT_W];
        end
        if (cmd.upd) begin
            if (func_reg == bba_pkg::FUNC_ALLOC && hit_reg) begin
                ram_we    = 1'b1;
                ram_waddr = hit_w_reg;
                ram_wdata = hit_data_reg | (bba_pkg::word_t'(1) << hit_b_reg);
            end else if (func_reg == bba_pkg::FUNC_FREE && !idx_oob && cur_bit) begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg[bba_pkg::IDX_W-1:bba_pkg::BIT_W];
                ram_wdata = dq & ~(bba_pkg::word_t'(1) << idx_reg[bba_pkg::BIT_W-1:0]);
            end
        end
    end

    always_comb begin
        count_next      = count_reg;
        res_status_next = bba_pkg::STAT_OK;
        res_num_next    = '0;
        res_bit_next    = 1'b0;
        if (cmd.fmt_init) begin
            count_next = tot_eff - res_eff;
        end
        if (cmd.upd) begin
            case (func_reg)
                bba_pkg::FUNC_FORMAT: begin
                    res_status_next = bba_pkg::STAT_OK;
                end
                bba_pkg::FUNC_ALLOC: begin
                    if (hit_reg) begin
                        res_num_next = {hit_w_reg, hit_b_reg};
                        count_next   = count_reg - bba_pkg::cnt_t'(1);
                    end else begin
                        res_status_next = bba_pkg::STAT_NO_FREE;
                    end
                end
                default: begin
                    res_num_next = idx_reg;
                    if (idx_oob) begin
                        res_status_next = bba_pkg::STAT_RANGE;
                    end else begin
                        res_bit_next = cur_bit;
                        if (func_reg == bba_pkg::FUNC_FREE && cur_bit &&
                            count_reg < bba_pkg::cnt_t'(bba_pkg::MAX_BLOCKS)) begin
                            count_next = count_reg + bba_pkg::cnt_t'(1);
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= bba_pkg::cnt_t'(bba_pkg::MAX_BLOCKS);
            valid_reg <= '0;
            chk_v_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (cmd.fmt_init) begin
                valid_reg <= '0;
            end else if (ram_we) begin
                valid_reg[ram_waddr] <= 1'b1;
            end
            if (cmd.scan_init) begin
                chk_v_reg <= 1'b0;
            end else if (cmd.scan_step) begin
                chk_v_reg <= scan_issue;
            end
            if (cmd.cap) begin
                hit_reg <= 1'b0;
            end else if (cmd.scan_step && scan_found) begin
                hit_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            func_reg <= in_func;
            idx_reg  <= in_idx;
        end
        if (cmd.fmt_init || cmd.scan_init) begin
            ctr_reg <= '0;
        end else if (cmd.fmt_step || scan_issue) begin
            ctr_reg <= ctr_reg + bba_pkg::wcnt_t'(1);
        end
        if (scan_issue) begin
            chk_w_reg <= ctr_reg[bba_pkg::WADDR_W-1:0];
        end
        if (ram_re) begin
            vq_reg <= valid_reg[ram_raddr];
        end
        if (cmd.scan_step && scan_found) begin
            hit_w_reg    <= chk_w_reg;
            hit_b_reg    <= first_free;
            hit_data_reg <= dq;
        end
        if (cmd.upd) begin
            res_status_reg <= res_status_next;
            res_num_reg    <= res_num_next;
            res_bit_reg    <= res_bit_next;
        end
        if (cmd.out_load) begin
            out_status_reg <= res_status_reg;
            out_num_reg    <= res_num_reg;
            out_bit_reg    <= res_bit_reg;
            out_cnt_reg    <= count_reg;
        end
    end

    assign m_tdata = bba_pkg::M_TDATA_W'({out_cnt_reg, out_bit_reg, out_num_reg, out_status_reg});

endmodule

`default_nettype wire

/* rtl/block_bitmap_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none

// First-fit block allocator. One map bit per block (1 used) lives in a
// 256 x 32 RAM, with a per-word valid flag in flip-flops so that reset and
// format need no clearing pass: a word not written since then reads as free.
// One operation is worked on at a time; the result waits in an output
// register so the next operation can be accepted meanwhile. Format makes
// one RAM write per reserved word, ceil(reserved/32) in all; allocate reads
// map words until the first free bit is found, at most ceil(total/32),
// through the single RAM read port, which the scan walks one word per cycle.
// A failed allocate with a zero count skips the scan. Configuration
// registers must be written only while the block is idle; the block
// itself does not enforce this.
module block_bitmap_allocator (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [1:0] func, [14:2] block_index, [15] zero
    input  wire logic [bba_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [1:0] status, [14:2] block_number, [15] bit_value, [29:16] free_count,
    // [31:30] zero
    output logic      [bba_pkg::M_TDATA_W-1:0] m_tdata,
    input  wire logic                          cfg_wr_en,
    input  wire logic                          cfg_index,
    input  wire logic [bba_pkg::CNT_W-1:0]     cfg_wdata
);

    bba_pkg::cnt_t  total_reg, reserved_reg;
    bba_pkg::cnt_t  tot_eff, res_eff;
    bba_pkg::cmd_t  cmd;
    bba_pkg::stat_t stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg    <= bba_pkg::cnt_t'(bba_pkg::MAX_BLOCKS);
            reserved_reg <= '0;
        end else if (cfg_wr_en) begin
            if (cfg_index == bba_pkg::REG_TOTAL) begin
                total_reg <= cfg_wdata;
            end else if (cfg_index == bba_pkg::REG_RESERVED) begin
                reserved_reg <= cfg_wdata;
            end
        end
    end

    // Both counts are clipped: total to the map size, reserved to total.
    assign tot_eff = (total_reg > bba_pkg::cnt_t'(bba_pkg::MAX_BLOCKS)) ?
                     bba_pkg::cnt_t'(bba_pkg::MAX_BLOCKS) : total_reg;
    assign res_eff = (reserved_reg > tot_eff) ? tot_eff : reserved_reg;

    bba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bba_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_func (bba_pkg::func_t'(s_tdata[1:0])),
        .in_idx  (s_tdata[bba_pkg::IDX_W+1:2]),
        .tot_eff (tot_eff),
        .res_eff (res_eff),
        .cmd     (cmd),
        .stat    (stat),
        .m_tdata (m_tdata)
    );

endmodule

`default_nettype wire

/* bench/tb_block_bitmap_allocator.sv */
`timescale 1ns / 1ps

module tb_block_bitmap_allocator;
    import bba_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int PHASES      = 16;
    localparam int PHASE_OPS   = 88;

    typedef struct packed {
        func_t func;
        idx_t  blk;
    } op_t;

    typedef struct packed {
        status_t status;
        idx_t    number;
        logic    used;
        cnt_t    free_cnt;
    } outcome_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_wr_en = 1'b0;
    logic                 cfg_index = REG_TOTAL;
    logic [CNT_W-1:0]     cfg_wdata = '0;

    // Shadow copy of the allocator state.
    bit blk_used [MAX_BLOCKS];
    int free_left = MAX_BLOCKS;
    int cfg_total = 8192;
    int cfg_reserved = 0;

    op_t      pending_ops [$];
    outcome_t replies_due [$];
    int       n_queued = 0;
    int       n_accepted = 0;
    int       n_replied = 0;
    int       errors = 0;
    int       send_gap = 0;
    bit       send_burst = 1'b0;
    int       recv_gap = 0;
    bit       recv_burst = 1'b0;
    int       quiet_cycles = 0;

    // Phase settings; -1 picks a random value.
    int ph_total [PHASES] = '{8192, 64, 1, 100, 33, 8192, 40, 3,
                              512, -1, 8192, 200, -1, 5000, -1, 16};
    int ph_res   [PHASES] = '{0, 0, 0, 37, 32, 8160, 8192, 0,
                              17, -1, 1, 199, -1, 4999, -1, 16};

    block_bitmap_allocator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    function automatic int managed_blocks();
        return (cfg_total > MAX_BLOCKS) ? MAX_BLOCKS : cfg_total;
    endfunction

    function automatic outcome_t predict_reply(op_t op);
        outcome_t r;
        int       lim;
        int       res;
        bit       hit;
        lim = managed_blocks();
        r.status   = STAT_OK;
        r.number   = '0;
        r.used     = 1'b0;
        hit        = 1'b0;
        case (op.func)
            FUNC_FORMAT: begin
                res = (cfg_reserved > lim) ? lim : cfg_reserved;
                for (int i = 0; i < MAX_BLOCKS; i++)
                    blk_used[i] = (i < res);
                free_left = lim - res;
            end
            FUNC_ALLOC: begin
                // First fit below the managed size, even if the count is stale.
                if (free_left != 0) begin
                    for (int i = 0; i < lim; i++) begin
                        if (!blk_used[i]) begin
                            r.number = idx_t'(i);
                            hit = 1'b1;
                            break;
                        end
                    end
                end
                if (hit) begin
                    blk_used[r.number] = 1'b1;
                    free_left--;
                end else begin
                    r.status = STAT_NO_FREE;
                end
            end
            default: begin
                r.number = op.blk;
                if (int'(op.blk) >= lim) begin
                    r.status = STAT_RANGE;
                end else begin
                    r.used = blk_used[op.blk];
                    if (op.func == FUNC_FREE && r.used) begin
                        blk_used[op.blk] = 1'b0;
                        if (free_left < MAX_BLOCKS)
                            free_left++;
                    end
                end
            end
        endcase
        r.free_cnt = cnt_t'(free_left);
        return r;
    endfunction

    function automatic op_t random_op(int alloc_pct);
        op_t op;
        int  lim;
        int  hot;
        int  pick;
        lim = managed_blocks();
        // Allocated blocks sit just above the reserved ones.
        hot = ((cfg_reserved > lim) ? lim : cfg_reserved) + 96;
        if (hot > lim)
            hot = lim;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            op.func = FUNC_FORMAT;
        else if (pick < 4 + alloc_pct)
            op.func = FUNC_ALLOC;
        else if (pick < 4 + alloc_pct + (96 - alloc_pct) / 2)
            op.func = FUNC_FREE;
        else
            op.func = FUNC_TEST;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            op.blk = idx_t'($urandom_range(0, hot - 1));
        else if (pick < 8)
            op.blk = idx_t'($urandom_range(0, MAX_BLOCKS - 1));
        else if (pick == 8)
            op.blk = idx_t'(lim - 1);
        else
            op.blk = idx_t'((lim < MAX_BLOCKS) ? lim : MAX_BLOCKS - 1);
        return op;
    endfunction

    task automatic queue_op(func_t f, int b);
        op_t op;
        op.func = f;
        op.blk  = idx_t'(b);
        pending_ops.push_back(op);
        n_queued++;
    endtask

    task automatic wait_idle();
        do @(posedge aclk);
        while (n_accepted != n_queued || n_replied < n_accepted);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, int value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[CNT_W-1:0];
        if (idx == REG_TOTAL)
            cfg_total = value;
        else
            cfg_reserved = value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_limits(int total, int reserved);
        write_reg(REG_TOTAL, total);
        write_reg(REG_RESERVED, reserved);
    endtask

    // Sender: one word per handshake, random gaps with occasional bursts.
    always @(posedge aclk) begin
        logic                 nxt_valid;
        logic [S_TDATA_W-1:0] nxt_data;
        op_t                  op;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            nxt_valid = s_tvalid;
            nxt_data  = s_tdata;
            if (s_tvalid && s_tready) begin
                op.func = func_t'(s_tdata[1:0]);
                op.blk  = s_tdata[14:2];
                replies_due.push_back(predict_reply(op));
                n_accepted++;
                nxt_valid = 1'b0;
                send_gap = send_burst ? 0 : $urandom_range(0, 10);
                if ($urandom_range(0, 39) == 0)
                    send_burst = !send_burst;
            end
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_ops.size() != 0) begin
                    op = pending_ops.pop_front();
                    nxt_data  = {1'b0, op.blk, op.func};
                    nxt_valid = 1'b1;
                end
            end
            s_tvalid <= nxt_valid;
            s_tdata  <= nxt_data;
        end
    end

    // Receiver: checks each word against the oldest prediction.
    always @(posedge aclk) begin
        logic     nxt_ready;
        outcome_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            nxt_ready = m_tready;
            if (m_tvalid && m_tready) begin
                n_replied++;
                if (replies_due.size() == 0) begin
                    $error("unexpected reply word %h", m_tdata);
                    errors++;
                end else begin
                    want = replies_due.pop_front();
                    if (m_tdata[1:0] !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_tdata[1:0]);
                        errors++;
                    end
                    if (m_tdata[14:2] !== want.number) begin
                        $error("block_number: expected %0d, got %0d",
                               want.number, m_tdata[14:2]);
                        errors++;
                    end
                    if (m_tdata[15] !== want.used) begin
                        $error("bit_value: expected %0d, got %0d", want.used, m_tdata[15]);
                        errors++;
                    end
                    if (m_tdata[29:16] !== want.free_cnt) begin
                        $error("free_count: expected %0d, got %0d",
                               want.free_cnt, m_tdata[29:16]);
                        errors++;
                    end
                end
                nxt_ready = 1'b0;
                recv_gap = recv_burst ? 0 : $urandom_range(0, 10);
                if ($urandom_range(0, 39) == 0)
                    recv_burst = !recv_burst;
            end
            if (!nxt_ready) begin
                if (recv_gap > 0)
                    recv_gap--;
                else
                    nxt_ready = 1'b1;
            end
            m_tready <= nxt_ready;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("tb_block_bitmap_allocator: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int total;
        int reserved;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Out of reset: empty map, full count, double free.
        queue_op(FUNC_TEST, 0);
        queue_op(FUNC_TEST, 8191);
        queue_op(FUNC_FREE, 8191);
        queue_op(FUNC_ALLOC, 0);
        queue_op(FUNC_ALLOC, 0);
        queue_op(FUNC_TEST, 1);
        queue_op(FUNC_FREE, 0);
        queue_op(FUNC_FREE, 0);
        queue_op(FUNC_ALLOC, 8191);
        wait_idle();

        // Nearly full map, exhaustion and out-of-range indexes.
        set_limits(40, 38);
        queue_op(FUNC_FORMAT, 5);
        queue_op(FUNC_ALLOC, 0);
        queue_op(FUNC_ALLOC, 0);
        queue_op(FUNC_ALLOC, 0);
        queue_op(FUNC_TEST, 40);
        queue_op(FUNC_FREE, 8191);
        queue_op(FUNC_FREE, 39);
        queue_op(FUNC_ALLOC, 0);
        wait_idle();

        // Shrinking the size without a format leaves the count out of step.
        set_limits(8192, 0);
        queue_op(FUNC_FORMAT, 0);
        wait_idle();
        write_reg(REG_TOTAL, 2);
        queue_op(FUNC_ALLOC, 0);
        queue_op(FUNC_ALLOC, 0);
        queue_op(FUNC_ALLOC, 0);
        wait_idle();

        // Reserved beyond the managed size.
        set_limits(5, 20);
        queue_op(FUNC_FORMAT, 0);
        queue_op(FUNC_TEST, 4);
        wait_idle();
        set_limits(8192, 8192);
        queue_op(FUNC_FORMAT, 0);
        queue_op(FUNC_ALLOC, 0);
        queue_op(FUNC_TEST, 8191);
        wait_idle();

        for (int ph = 0; ph < PHASES; ph++) begin
            total    = ph_total[ph];
            reserved = ph_res[ph];
            if (total < 0) begin
                total = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_BLOCKS)
                                                    : $urandom_range(1, 300);
                reserved = $urandom_range(0, total + 8);
                if (reserved > MAX_BLOCKS)
                    reserved = MAX_BLOCKS;
            end
            set_limits(total, reserved);
            // Two phases keep the old map to work on a stale count.
            if (ph != 7 && ph != 11)
                queue_op(FUNC_FORMAT, $urandom_range(0, MAX_BLOCKS - 1));
            for (int k = 0; k < PHASE_OPS; k++) begin
                pending_ops.push_back(random_op(30 + (ph % 4) * 10));
                n_queued++;
            end
            wait_idle();
        end

        repeat (300) @(posedge aclk);
        if (replies_due.size() != 0) begin
            $error("%0d replies never arrived", replies_due.size());
            errors++;
        end
        if (errors == 0)
            $display("tb_block_bitmap_allocator: clean");
        else
            $display("tb_block_bitmap_allocator: errors");
        $finish;
    end

endmodule
